>>> design/ccr_pkg.sv
// Shared types, constants and arithmetic helpers for the contact collision response block.
package ccr_pkg;

  localparam int unsigned NormW     = 18;
  localparam int unsigned ValW      = 32;
  localparam int unsigned DistW     = 33;
  localparam int unsigned BounceW   = 18;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic signed [DistW-1:0] MarginQ16 = 33'sd66;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_FIRST  = 2'd1,
    OP_SECOND = 2'd2,
    OP_BOTH   = 2'd3
  } ccr_op_e;

  typedef struct packed {
    ccr_op_e                    op;
    logic signed [NormW-1:0]    nx;
    logic signed [NormW-1:0]    ny;
    logic signed [DistW-1:0]    sep;
    logic [BounceW-1:0]         bounce;
    logic signed [ValW-1:0]     v1x;
    logic signed [ValW-1:0]     v1y;
    logic signed [ValW-1:0]     v2x;
    logic signed [ValW-1:0]     v2y;
  } ccr_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ccr_qstat_t;

  function automatic logic signed [31:0] ccr_sat(input logic signed [43:0] v);
    logic signed [31:0] r;
    if (v > 44'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -44'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round half up, product scaled down by 2^16.
  function automatic logic signed [42:0] ccr_rnd16(input logic signed [57:0] v);
    logic signed [58:0] t;
    t = 59'(v) + 59'sd32768;
    return t[58:16];
  endfunction

  // Round half up, product scaled down by 2^17.
  function automatic logic signed [41:0] ccr_rnd17(input logic signed [57:0] v);
    logic signed [58:0] t;
    t = 59'(v) + 59'sd65536;
    return t[58:17];
  endfunction

endpackage

>>> design/ccr_front.sv
// Front end: accepts contact requests, adds the margin and classifies the body mode.
module ccr_front import ccr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [NormW-1:0]    normal_x_i,
  input  logic signed [NormW-1:0]    normal_y_i,
  input  logic signed [ValW-1:0]     penetration_i,
  input  logic [BounceW-1:0]         bounciness_sum_i,
  input  logic [ModeW-1:0]           dynamic_mode_i,
  input  logic signed [ValW-1:0]     first_velocity_x_i,
  input  logic signed [ValW-1:0]     first_velocity_y_i,
  input  logic signed [ValW-1:0]     second_velocity_x_i,
  input  logic signed [ValW-1:0]     second_velocity_y_i,
  input  ccr_qstat_t                 qstat_i,
  output logic                       push_o,
  output ccr_item_t                  item_o
);

  logic      valid_q, valid_d;
  ccr_item_t item_q;
  ccr_op_e   op;
  logic      accept;

  always_comb begin
    unique case (dynamic_mode_i)
      2'd1:    op = OP_FIRST;
      2'd2:    op = OP_SECOND;
      2'd3:    op = OP_BOTH;
      default: op = OP_NONE;
    endcase
  end

  assign push_o     = valid_q && !qstat_i.full;
  assign in_stall_o = valid_q && qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op     <= op;
      item_q.nx     <= normal_x_i;
      item_q.ny     <= normal_y_i;
      item_q.sep    <= DistW'(penetration_i) + MarginQ16;
      item_q.bounce <= bounciness_sum_i;
      item_q.v1x    <= first_velocity_x_i;
      item_q.v1y    <= first_velocity_y_i;
      item_q.v2x    <= second_velocity_x_i;
      item_q.v2y    <= second_velocity_y_i;
    end
  end

endmodule

>>> design/ccr_queue.sv
// Short request queue between the front end and the arithmetic back end.
module ccr_queue import ccr_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ccr_item_t  item_i,
  input  logic       pop_i,
  output ccr_item_t  item_o,
  output ccr_qstat_t qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ccr_item_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CntW'(Depth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

>>> design/ccr_back.sv
// Back end: six-stage multiply pipeline that splits velocities and applies the response.
module ccr_back import ccr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ccr_qstat_t             qstat_i,
  input  ccr_item_t              item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [ValW-1:0] shift_o [4],
  output logic signed [ValW-1:0] vel_o [4]
);

  // Lanes: 0 first x, 1 first y, 2 second x, 3 second y.
  logic [5:0] vld_q, vld_d;
  logic       en;

  ccr_op_e                  op_q [5];
  logic signed [NormW-1:0]  nx_q [2];
  logic signed [NormW-1:0]  ny_q [2];
  logic [BounceW-1:0]       b_q [4];
  logic signed [ValW-1:0]   v_q [5][4];

  logic signed [49:0] p_q [4];
  logic signed [50:0] dn_q [2];
  logic signed [35:0] dot_q [2];
  logic signed [35:0] sh_q [4][2];
  logic signed [53:0] qn_q [4];
  logic signed [38:0] vn_q [4];
  logic signed [39:0] vp_q [2][4];
  logic signed [57:0] r_q [4];
  logic signed [ValW-1:0] sho_q [4];
  logic signed [ValW-1:0] vo_q [4];

  logic signed [ValW-1:0] vin [4];
  logic signed [51:0] dsum [2];
  logic signed [51:0] shsum [2];
  logic signed [35:0] shr [2];
  logic signed [54:0] vnsum [4];
  logic signed [38:0] vnr [4];
  logic signed [ValW-1:0] sho [4];
  logic signed [ValW-1:0] vo [4];

  assign en          = !vld_q[5] || !out_stall_i;
  assign pop_o       = en && !qstat_i.empty;
  assign out_valid_o = vld_q[5];
  assign vin[0] = item_i.v1x;
  assign vin[1] = item_i.v1y;
  assign vin[2] = item_i.v2x;
  assign vin[3] = item_i.v2y;

  always_comb begin
    vld_d = vld_q;
    if (en) begin
      vld_d = {vld_q[4:0], !qstat_i.empty};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      dsum[j]  = 52'(p_q[2*j]) + 52'(p_q[2*j+1]) + 52'sd32768;
      shsum[j] = 52'(dn_q[j]) + ((op_q[0] == OP_BOTH) ? 52'sd65536 : 52'sd32768);
      shr[j]   = (op_q[0] == OP_BOTH) ? 36'($signed(shsum[j][51:17])) : shsum[j][51:16];
    end
    for (int l = 0; l < 4; l++) begin
      vnsum[l] = 55'(qn_q[l]) + 55'sd32768;
      vnr[l]   = vnsum[l][54:16];
    end
    for (int a = 0; a < 2; a++) begin
      // A body that does not move gets no shift and keeps its velocity.
      sho[a]   = ((op_q[4] == OP_FIRST) || (op_q[4] == OP_BOTH)) ?
                 ccr_sat(44'(sh_q[3][a])) : '0;
      sho[a+2] = ((op_q[4] == OP_SECOND) || (op_q[4] == OP_BOTH)) ?
                 ccr_sat(-44'(sh_q[3][a])) : '0;
      unique case (op_q[4])
        OP_FIRST: begin
          vo[a]   = ccr_sat(44'(vp_q[1][a]) - 44'(ccr_rnd16(r_q[a])));
          vo[a+2] = v_q[4][a+2];
        end
        OP_SECOND: begin
          vo[a]   = v_q[4][a];
          vo[a+2] = ccr_sat(44'(vp_q[1][a+2]) - 44'(ccr_rnd16(r_q[a+2])));
        end
        OP_BOTH: begin
          vo[a]   = ccr_sat(44'(vp_q[1][a]) + 44'(ccr_rnd17(r_q[a+2])));
          vo[a+2] = ccr_sat(44'(vp_q[1][a+2]) + 44'(ccr_rnd17(r_q[a])));
        end
        default: begin
          vo[a]   = v_q[4][a];
          vo[a+2] = v_q[4][a+2];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 1: velocity and distance products with the normal.
      op_q[0] <= item_i.op;
      nx_q[0] <= item_i.nx;
      ny_q[0] <= item_i.ny;
      b_q[0]  <= item_i.bounce;
      for (int l = 0; l < 4; l++) begin
        v_q[0][l] <= vin[l];
        p_q[l]    <= ((l % 2) == 0) ? 50'(item_i.nx) * 50'(vin[l])
                                    : 50'(item_i.ny) * 50'(vin[l]);
      end
      dn_q[0] <= 51'(item_i.sep) * 51'(item_i.nx);
      dn_q[1] <= 51'(item_i.sep) * 51'(item_i.ny);
      // Stage 2: rounded dot products and shifts.
      op_q[1] <= op_q[0];
      nx_q[1] <= nx_q[0];
      ny_q[1] <= ny_q[0];
      b_q[1]  <= b_q[0];
      v_q[1]  <= v_q[0];
      dot_q   <= '{dsum[0][51:16], dsum[1][51:16]};
      sh_q[0] <= shr;
      // Stage 3: normal part products.
      op_q[2] <= op_q[1];
      b_q[2]  <= b_q[1];
      v_q[2]  <= v_q[1];
      sh_q[1] <= sh_q[0];
      for (int l = 0; l < 4; l++) begin
        qn_q[l] <= ((l % 2) == 0) ? 54'(nx_q[1]) * 54'(dot_q[l/2])
                                  : 54'(ny_q[1]) * 54'(dot_q[l/2]);
      end
      // Stage 4: normal part and remainder.
      op_q[3] <= op_q[2];
      b_q[3]  <= b_q[2];
      v_q[3]  <= v_q[2];
      sh_q[2] <= sh_q[1];
      for (int l = 0; l < 4; l++) begin
        vn_q[l]    <= vnr[l];
        vp_q[0][l] <= 40'(v_q[2][l]) - 40'(vnr[l]);
      end
      // Stage 5: bounciness products.
      op_q[4] <= op_q[3];
      v_q[4]  <= v_q[3];
      vp_q[1] <= vp_q[0];
      sh_q[3] <= sh_q[2];
      for (int l = 0; l < 4; l++) begin
        r_q[l] <= 58'($signed({1'b0, b_q[3]})) * 58'(vn_q[l]);
      end
      // Stage 6: result register.
      sho_q <= sho;
      vo_q  <= vo;
    end
  end

  assign shift_o = sho_q;
  assign vel_o   = vo_q;

endmodule

>>> design/contact_collision_response_2d.sv
// Top level of the 2D contact collision response block.
// Resolves one contact between two equal-mass bodies in Q15.16 fixed point and returns
// position shifts and new velocities, saturated to 32 bits. One contact is taken every
// clock cycle unless in_stall_o is high; a request passes through one front register, one
// queue slot and the six back-end stages before its result appears. The back-end multiply
// pipeline advances as a whole when its output register is free or taken. The queue lets
// the front keep accepting while the output is stalled until it fills.
module contact_collision_response_2d import ccr_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [NormW-1:0]    normal_x_i,
  input  logic signed [NormW-1:0]    normal_y_i,
  input  logic signed [ValW-1:0]     penetration_i,
  input  logic [BounceW-1:0]         bounciness_sum_i,
  input  logic [ModeW-1:0]           dynamic_mode_i,
  input  logic signed [ValW-1:0]     first_velocity_x_i,
  input  logic signed [ValW-1:0]     first_velocity_y_i,
  input  logic signed [ValW-1:0]     second_velocity_x_i,
  input  logic signed [ValW-1:0]     second_velocity_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [ValW-1:0]     first_shift_x_o,
  output logic signed [ValW-1:0]     first_shift_y_o,
  output logic signed [ValW-1:0]     second_shift_x_o,
  output logic signed [ValW-1:0]     second_shift_y_o,
  output logic signed [ValW-1:0]     first_new_vx_o,
  output logic signed [ValW-1:0]     first_new_vy_o,
  output logic signed [ValW-1:0]     second_new_vx_o,
  output logic signed [ValW-1:0]     second_new_vy_o
);

  ccr_qstat_t             qstat;
  ccr_item_t              push_item, pop_item;
  logic                   push, pop;
  logic signed [ValW-1:0] shift [4];
  logic signed [ValW-1:0] vel [4];

  ccr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .normal_x_i, .normal_y_i, .penetration_i, .bounciness_sum_i, .dynamic_mode_i,
    .first_velocity_x_i, .first_velocity_y_i, .second_velocity_x_i, .second_velocity_y_i,
    .qstat_i (qstat),
    .push_o  (push),
    .item_o  (push_item)
  );

  ccr_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .qstat_o (qstat)
  );

  ccr_back u_back (
    .clk_i, .rst_ni,
    .qstat_i     (qstat),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .shift_o     (shift),
    .vel_o       (vel)
  );

  assign first_shift_x_o  = shift[0];
  assign first_shift_y_o  = shift[1];
  assign second_shift_x_o = shift[2];
  assign second_shift_y_o = shift[3];
  assign first_new_vx_o   = vel[0];
  assign first_new_vy_o   = vel[1];
  assign second_new_vx_o  = vel[2];
  assign second_new_vy_o  = vel[3];

endmodule
